// ===== hdl/ptog_pkg.sv =====
// Shared types and constants for the point to occupancy grid block.
`timescale 1ns / 1ps

package ptog_pkg;

    localparam int WORD_BITS = 64;
    localparam int INDEX_BITS = 8;

    localparam logic MODE_PLOT = 1'b0;
    localparam logic MODE_READ = 1'b1;

    typedef struct packed {
        logic               mode;
        logic signed [15:0] x_mm;
        logic signed [15:0] y_mm;
    } item_t;

    typedef struct packed {
        logic [WORD_BITS-1:0]  cells;
        logic [INDEX_BITS-1:0] word_index;
        logic                  last_word;
    } result_t;

    typedef struct packed {
        logic mul_en;
        logic fix_en;
    } axis_ctrl_t;

endpackage

// ===== hdl/point_to_occupancy_grid_top.sv =====
// Plot: per point, multiply, correction, address and read, write back; off grid, no write back.
// Read: per word, bitmap read, then clear and output load, which waits while the output stalls.
// One item at a time; the bitmap memory's read-modify-write port sets the rate.
// After reset a clearing pass zeroes the bitmap, one word a cycle (157 words at default),
// with input stalled; control registers reset asynchronously, the read pointer to zero.
`timescale 1ns / 1ps

module point_to_occupancy_grid_top #(
    parameter int GRID_SIZE = 100,
    parameter int SPAN_MM   = 10000
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              item_valid,
    output logic              item_stall,
    input  ptog_pkg::item_t   item,
    output logic              result_valid,
    input  logic              result_stall,
    output ptog_pkg::result_t result
);

    localparam int GRID_CELLS = GRID_SIZE * GRID_SIZE;
    localparam int GRID_WORDS = (GRID_CELLS + ptog_pkg::WORD_BITS - 1) / ptog_pkg::WORD_BITS;
    localparam int AW = (GRID_WORDS > 1) ? $clog2(GRID_WORDS) : 1;
    localparam int IW = $clog2(GRID_SIZE);
    localparam int LW = $clog2(GRID_CELLS);
    localparam logic [AW-1:0] LAST_ADDR = AW'(GRID_WORDS - 1);

    localparam logic [2:0] ST_CLEAR = 3'd0;
    localparam logic [2:0] ST_IDLE  = 3'd1;
    localparam logic [2:0] ST_FIX   = 3'd2;
    localparam logic [2:0] ST_LIN   = 3'd3;
    localparam logic [2:0] ST_PWR   = 3'd4;
    localparam logic [2:0] ST_RDATA = 3'd5;

    logic [2:0]    state_reg;
    logic [2:0]    state_next;
    logic [AW-1:0] clr_cnt_reg;
    logic [AW-1:0] ptr_reg;
    logic [LW-1:0] lin_reg;
    logic [63:0]   rdata_reg;
    logic          out_valid_reg;
    ptog_pkg::result_t out_reg;

    logic [63:0] grid_mem [GRID_WORDS];

    ptog_pkg::axis_ctrl_t axis_ctrl;
    logic [IW-1:0] row_idx;
    logic [IW-1:0] col_idx;
    logic          row_ok;
    logic          col_ok;

    logic          accept;
    logic          slot_free;
    logic [AW-1:0] rd_ptr;
    logic          rd_last;
    logic [LW-1:0] lin;
    logic          mem_re;
    logic [AW-1:0] mem_raddr;
    logic          mem_we;
    logic [AW-1:0] mem_waddr;
    logic [63:0]   mem_wdata;

    assign item_stall = (state_reg != ST_IDLE);
    assign accept     = item_valid && !item_stall;
    assign slot_free  = !out_valid_reg || !result_stall;

    assign rd_ptr  = (ptr_reg > LAST_ADDR) ? '0 : ptr_reg;
    assign rd_last = (rd_ptr == LAST_ADDR);

    assign axis_ctrl.mul_en = accept && (item.mode == ptog_pkg::MODE_PLOT);
    assign axis_ctrl.fix_en = (state_reg == ST_FIX);

    ptog_axis #(.GRID_SIZE(GRID_SIZE), .SPAN_MM(SPAN_MM)) u_row (
        .clk  (clk),
        .ctrl (axis_ctrl),
        .mm   (item.x_mm),
        .idx  (row_idx),
        .ok   (row_ok)
    );

    ptog_axis #(.GRID_SIZE(GRID_SIZE), .SPAN_MM(SPAN_MM)) u_col (
        .clk  (clk),
        .ctrl (axis_ctrl),
        .mm   (item.y_mm),
        .idx  (col_idx),
        .ok   (col_ok)
    );

    assign lin = LW'(row_idx) * LW'(GRID_SIZE) + LW'(col_idx);

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_CLEAR:
            begin
                if (clr_cnt_reg == LAST_ADDR)
                    state_next = ST_IDLE;
            end
            ST_IDLE:
            begin
                if (accept)
                    state_next = (item.mode == ptog_pkg::MODE_READ) ? ST_RDATA : ST_FIX;
            end
            ST_FIX:
            begin
                state_next = ST_LIN;
            end
            ST_LIN:
            begin
                state_next = (row_ok && col_ok) ? ST_PWR : ST_IDLE;
            end
            ST_PWR:
            begin
                state_next = ST_IDLE;
            end
            ST_RDATA:
            begin
                if (slot_free)
                    state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_CLEAR;
            end
        endcase
    end

    always_comb
    begin
        mem_re    = 1'b0;
        mem_raddr = rd_ptr;
        mem_we    = 1'b0;
        mem_waddr = rd_ptr;
        mem_wdata = '0;
        if (state_reg == ST_IDLE && accept && item.mode == ptog_pkg::MODE_READ)
        begin
            mem_re = 1'b1;
        end
        if (state_reg == ST_LIN && row_ok && col_ok)
        begin
            mem_re    = 1'b1;
            mem_raddr = AW'(lin >> 6);
        end
        case (state_reg)
            ST_CLEAR:
            begin
                mem_we    = 1'b1;
                mem_waddr = clr_cnt_reg;
            end
            ST_PWR:
            begin
                mem_we    = 1'b1;
                mem_waddr = AW'(lin_reg >> 6);
                mem_wdata = rdata_reg | (64'd1 << lin_reg[5:0]);
            end
            ST_RDATA:
            begin
                mem_we = slot_free;
            end
            default:
            begin
                mem_we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
            grid_mem[mem_waddr] <= mem_wdata;
        if (mem_re)
            rdata_reg <= grid_mem[mem_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_LIN)
            lin_reg <= lin;
        if (state_reg == ST_RDATA && slot_free)
        begin
            out_reg.cells      <= rdata_reg;
            out_reg.word_index <= ptog_pkg::INDEX_BITS'(rd_ptr);
            out_reg.last_word  <= rd_last;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            clr_cnt_reg   <= '0;
            ptr_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == ST_CLEAR)
                clr_cnt_reg <= clr_cnt_reg + AW'(1);
            if (state_reg == ST_RDATA && slot_free)
            begin
                ptr_reg       <= rd_last ? '0 : rd_ptr + AW'(1);
                out_valid_reg <= 1'b1;
            end
            else if (!result_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign result_valid = out_valid_reg;
    assign result       = out_reg;

`ifndef SYNTH
    a_rise_from_read: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(result_valid) |-> $past(state_reg) == ST_RDATA)
        else $error("result loaded outside a read");

    a_ptr_range: assert property (@(posedge clk) disable iff (!rst_n)
        ptr_reg <= LAST_ADDR)
        else $error("read pointer past last word");

    a_plot_in_grid: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_PWR |-> row_ok && col_ok && $past(state_reg) == ST_LIN)
        else $error("write back of a dropped point");

    a_last_index: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.last_word
            |-> result.word_index == ptog_pkg::INDEX_BITS'(GRID_WORDS - 1))
        else $error("last word flag on wrong index");
`endif

endmodule

// ===== hdl/ptog_axis.sv =====
// One axis of the coordinate to grid index mapping, by reciprocal multiply.
`timescale 1ns / 1ps

module ptog_axis #(
    parameter int GRID_SIZE = 100,
    parameter int SPAN_MM   = 10000
) (
    input  logic                         clk,
    input  ptog_pkg::axis_ctrl_t         ctrl,
    input  logic signed [15:0]           mm,
    output logic [$clog2(GRID_SIZE)-1:0] idx,
    output logic                         ok
);

    localparam int DEN = 2 * SPAN_MM;
    localparam int TW  = $clog2(65535 + SPAN_MM) + 1;
    localparam int DW  = $clog2(DEN);
    localparam int IW  = $clog2(GRID_SIZE);
    localparam int GW  = $clog2(GRID_SIZE + 1);
    localparam int KW  = $clog2(2 * GRID_SIZE + 1);
    localparam int PKW = DW + KW;
    localparam int PGW = DW + GW;
    localparam longint K = ((longint'(1) << DW) * GRID_SIZE) / DEN;
    localparam logic signed [TW-1:0] DEN_T  = TW'(DEN);
    localparam logic signed [TW-1:0] SPAN_T = TW'(SPAN_MM);

    logic signed [TW-1:0] mm_ext;
    logic signed [TW-1:0] t;
    logic                 in_range;
    logic [DW-1:0]        tu;
    logic [IW-1:0]        q_est;
    logic [PGW-1:0]       qd;
    logic [PGW-1:0]       rem;

    logic [PKW-1:0] prod_k_reg;
    logic [PGW-1:0] prod_g_reg;
    logic           ok_reg;
    logic [IW-1:0]  idx_reg;

    assign mm_ext   = TW'(mm);
    assign t        = (mm_ext <<< 1) + SPAN_T;
    assign in_range = !t[TW-1] && (t < DEN_T);
    assign tu       = t[DW-1:0];

    // estimate is exact or one low; one compare fixes it
    assign q_est = IW'(prod_k_reg >> DW);
    assign qd    = PGW'(q_est) * PGW'(DEN);
    assign rem   = prod_g_reg - qd;

    always_ff @(posedge clk)
    begin
        if (ctrl.mul_en)
        begin
            prod_k_reg <= PKW'(tu) * PKW'(K);
            prod_g_reg <= PGW'(tu) * PGW'(GRID_SIZE);
            ok_reg     <= in_range;
        end
        if (ctrl.fix_en)
        begin
            idx_reg <= q_est + IW'(rem >= PGW'(DEN));
        end
    end

    assign idx = idx_reg;
    assign ok  = ok_reg;

endmodule

// ===== tb/point_to_occupancy_grid_top_tb.sv =====
// Self-checking testbench for the point to occupancy grid block: plots, word reads and readout wrap.
`timescale 1ns / 1ps

module point_to_occupancy_grid_top_tb;

    localparam int GRID_SIZE   = 100;
    localparam int SPAN_MM     = 10000;
    localparam int GRID_CELLS  = GRID_SIZE * GRID_SIZE;
    localparam int GRID_WORDS  = (GRID_CELLS + ptog_pkg::WORD_BITS - 1) / ptog_pkg::WORD_BITS;
    localparam int ITEM_TARGET = 1650;
    localparam int CYCLE_LIMIT = 400000;
    localparam int LONG_HOLD   = 400;
    localparam int DRAIN_WAIT  = 20;

    logic              clk;
    logic              rst_n;
    logic              item_valid;
    logic              item_stall;
    ptog_pkg::item_t   item;
    logic              result_valid;
    logic              result_stall;
    ptog_pkg::result_t result;

    ptog_pkg::item_t   pending_items[$];
    ptog_pkg::result_t expected_words[$];

    logic [ptog_pkg::WORD_BITS-1:0] grid_shadow[GRID_WORDS];
    int read_ptr;

    int total_items;
    int items_accepted;
    int words_checked;
    int error_count;
    int plot_count;
    int off_grid_count;
    int read_count;
    int sweep_count;
    int cycle_count;
    bit item_took;

    int gap_left;
    int burst_left;
    int hold_left;
    bit hold_done;
    int stall_phase_left;
    int stall_pct;

    point_to_occupancy_grid_top #(
        .GRID_SIZE(GRID_SIZE),
        .SPAN_MM  (SPAN_MM)
    ) dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .item_valid  (item_valid),
        .item_stall  (item_stall),
        .item        (item),
        .result_valid(result_valid),
        .result_stall(result_stall),
        .result      (result)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // floor((2*mm + SPAN) * GRID / (2*SPAN)), or -1 when off the grid
    function automatic int mm_to_cell(input logic signed [15:0] mm);
        longint num;
        longint idx;
        num = (2 * longint'(mm) + SPAN_MM) * GRID_SIZE;
        if (num < 0)
            return -1;
        idx = num / (2 * SPAN_MM);
        if (idx >= GRID_SIZE)
            return -1;
        return int'(idx);
    endfunction

    function automatic ptog_pkg::item_t make_item(input logic m, input logic signed [15:0] x,
                                                  input logic signed [15:0] y);
        ptog_pkg::item_t it;
        it.mode = m;
        it.x_mm = x;
        it.y_mm = y;
        return it;
    endfunction

    function automatic logic signed [15:0] pick_mm(input int center);
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 16'(int'($urandom_range(0, 9999)) - 5000);
        else if (r < 70)
            return 16'(center + int'($urandom_range(0, 600)) - 300);
        else if (r < 85)
            return 16'(($urandom_range(0, 1) ? 5000 : -5000) + int'($urandom_range(0, 240)) - 120);
        else
            return 16'($urandom);
    endfunction

    task automatic update_grid(input ptog_pkg::item_t it);
        int row;
        int col;
        int lin;
        int p;
        ptog_pkg::result_t r;
        if (it.mode == ptog_pkg::MODE_PLOT)
        begin
            plot_count++;
            row = mm_to_cell(it.x_mm);
            col = mm_to_cell(it.y_mm);
            if (row >= 0 && col >= 0)
            begin
                lin = row * GRID_SIZE + col;
                grid_shadow[lin / ptog_pkg::WORD_BITS][lin % ptog_pkg::WORD_BITS] = 1'b1;
            end
            else
                off_grid_count++;
        end
        else
        begin
            read_count++;
            p = read_ptr;
            if (p >= GRID_WORDS)
                p = 0;
            r.cells      = grid_shadow[p];
            r.word_index = ptog_pkg::INDEX_BITS'(p);
            r.last_word  = (p == GRID_WORDS - 1);
            expected_words.push_back(r);
            grid_shadow[p] = '0;
            read_ptr = r.last_word ? 0 : p + 1;
            if (r.last_word)
                sweep_count++;
        end
    endtask

    // input transfers feed the grid shadow; output transfers are checked in order
    always @(posedge clk)
    begin
        ptog_pkg::result_t exp_word;
        item_took = rst_n && item_valid && !item_stall;
        if (item_took)
        begin
            update_grid(item);
            items_accepted++;
        end
        if (rst_n && result_valid && !result_stall)
        begin
            if (expected_words.size() == 0)
            begin
                $error("unexpected result transfer: word_index %0d", result.word_index);
                error_count++;
            end
            else
            begin
                exp_word = expected_words.pop_front();
                if (result.cells !== exp_word.cells)
                begin
                    $error("cells: expected %h, got %h", exp_word.cells, result.cells);
                    error_count++;
                end
                if (result.word_index !== exp_word.word_index)
                begin
                    $error("word_index: expected %0d, got %0d",
                           exp_word.word_index, result.word_index);
                    error_count++;
                end
                if (result.last_word !== exp_word.last_word)
                begin
                    $error("last_word: expected %0d, got %0d",
                           exp_word.last_word, result.last_word);
                    error_count++;
                end
            end
            words_checked++;
        end
    end

    // sender: bursts of random length separated by random gaps
    always @(negedge clk)
    begin
        if (rst_n && !(item_valid && !item_took))
        begin
            if (gap_left > 0)
            begin
                gap_left--;
                item_valid <= 1'b0;
            end
            else if (pending_items.size() > 0)
            begin
                item       <= pending_items.pop_front();
                item_valid <= 1'b1;
                burst_left--;
                if (burst_left <= 0)
                begin
                    burst_left = $urandom_range(1, 40);
                    gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
                end
            end
            else
                item_valid <= 1'b0;
        end
    end

    // receiver: phases of varying stall density, plus one long hold-off
    always @(negedge clk)
    begin
        if (!rst_n)
            result_stall <= 1'b0;
        else if (hold_left > 0)
        begin
            hold_left--;
            result_stall <= 1'b1;
        end
        else if (!hold_done && words_checked >= 60)
        begin
            hold_done = 1'b1;
            hold_left = LONG_HOLD - 1;
            result_stall <= 1'b1;
        end
        else
        begin
            if (stall_phase_left <= 0)
            begin
                stall_phase_left = $urandom_range(10, 80);
                case ($urandom_range(0, 3))
                    0, 1: stall_pct = 0;
                    2:    stall_pct = 30;
                    default: stall_pct = 75;
                endcase
            end
            stall_phase_left--;
            result_stall <= ($urandom_range(0, 99) < stall_pct);
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycle_count);
            $display("point_to_occupancy_grid_top_tb: done, errors");
            $finish;
        end
    end

    initial
    begin
        int n;
        int cx;
        int cy;
        rst_n        = 1'b0;
        item_valid   = 1'b0;
        item         = '0;
        result_stall = 1'b0;
        foreach (grid_shadow[i])
            grid_shadow[i] = '0;
        read_ptr   = 0;
        burst_left = 1;
        gap_left   = 0;

        // directed: grid edges, off-grid points, negative fraction, first words
        pending_items.push_back(make_item(ptog_pkg::MODE_PLOT, -16'sd5000, -16'sd5000));
        pending_items.push_back(make_item(ptog_pkg::MODE_PLOT, -16'sd5001, 16'sd0));
        pending_items.push_back(make_item(ptog_pkg::MODE_PLOT, 16'sd0, -16'sd5001));
        pending_items.push_back(make_item(ptog_pkg::MODE_PLOT, 16'sd4999, 16'sd4999));
        pending_items.push_back(make_item(ptog_pkg::MODE_PLOT, 16'sd5000, 16'sd0));
        pending_items.push_back(make_item(ptog_pkg::MODE_PLOT, 16'sd0, 16'sd5000));
        pending_items.push_back(make_item(ptog_pkg::MODE_PLOT, -16'sd32768, -16'sd32768));
        pending_items.push_back(make_item(ptog_pkg::MODE_PLOT, 16'sd32767, 16'sd32767));
        pending_items.push_back(make_item(ptog_pkg::MODE_PLOT, -16'sd32768, 16'sd32767));
        pending_items.push_back(make_item(ptog_pkg::MODE_PLOT, 16'sd0, 16'sd0));
        pending_items.push_back(make_item(ptog_pkg::MODE_PLOT, -16'sd4901, -16'sd4900));
        pending_items.push_back(make_item(ptog_pkg::MODE_PLOT, -16'sd4951, -16'sd5000));
        pending_items.push_back(make_item(ptog_pkg::MODE_PLOT, 16'sd4950, -16'sd5000));
        pending_items.push_back(make_item(ptog_pkg::MODE_PLOT, -16'sd1, -16'sd1));
        pending_items.push_back(make_item(ptog_pkg::MODE_PLOT, 16'sd0, 16'sd0));
        repeat (8)
            pending_items.push_back(make_item(ptog_pkg::MODE_READ,
                                              16'($urandom), 16'($urandom)));

        // random: runs of reads and runs of plots around a moving cluster center
        while (pending_items.size() < ITEM_TARGET)
        begin
            if ($urandom_range(0, 99) < 35)
            begin
                n = $urandom_range(1, 40);
                repeat (n)
                    pending_items.push_back(make_item(ptog_pkg::MODE_READ,
                                                      16'($urandom), 16'($urandom)));
            end
            else
            begin
                n  = $urandom_range(1, 30);
                cx = int'($urandom_range(0, 9999)) - 5000;
                cy = int'($urandom_range(0, 9999)) - 5000;
                repeat (n)
                    pending_items.push_back(make_item(ptog_pkg::MODE_PLOT,
                                                      pick_mm(cx), pick_mm(cy)));
            end
        end
        total_items = pending_items.size();

        repeat (10) @(negedge clk);
        rst_n = 1'b1;

        while (!(items_accepted == total_items && expected_words.size() == 0))
            @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);

        $display("%0d items: %0d plots (%0d off grid), %0d word reads over %0d full sweeps",
                 total_items, plot_count, off_grid_count, read_count, sweep_count);
        $display("%0d words checked, long output hold-off %0s, %0d errors",
                 words_checked, hold_done ? "applied" : "not reached", error_count);
        if (error_count == 0)
            $display("point_to_occupancy_grid_top_tb: done, clean");
        else
            $display("point_to_occupancy_grid_top_tb: done, errors");
        $finish;
    end

endmodule
